/* hw/rtl/tws_pkg.sv */
// Shared types and constants for the three-wire SPI register master.
// Payload structs of both channels, the command word passed from the
// front to the back, and default geometry. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

  // Default geometry of the serial frame
  localparam int unsigned DATA_BITS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF = 8;

  // Fixed field widths of the channels
  localparam int unsigned REG_ADDR_W   = 7;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ADDR_BYTE_W  = 8;

  // Read flag in the address byte
  localparam logic [ADDR_BYTE_W-1:0] READ_FLAG = 8'h80;

  // Function codes of an input item
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned CMD_QUEUE_PTR_W = $clog2(CMD_QUEUE_DEPTH);
  localparam int unsigned CMD_QUEUE_CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } tws_cmd_kind_e;

  typedef struct packed {
    logic                  func;
    logic                  is_read;
    logic [REG_ADDR_W-1:0] reg_addr;
    logic [WORD_W-1:0]     write_data;
    logic                  sda_in;
  } tws_in_t;

  typedef struct packed {
    logic              select_n;
    logic              serial_clock;
    logic              data_out;
    logic              data_drive;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_data;
  } tws_out_t;

  // Classified command: start fields are zero for ticks
  typedef struct packed {
    tws_cmd_kind_e          kind;
    logic                   is_read;
    logic [ADDR_BYTE_W-1:0] addr_byte;
    logic [WORD_W-1:0]      write_data;
    logic                   sda_in;
  } tws_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/tws_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on tws_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface tws_in_if import tws_pkg::*; ();
  logic    valid;
  logic    ready;
  tws_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tws_out_if import tws_pkg::*; ();
  logic     valid;
  logic     ready;
  tws_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tws_front.sv */
// Front end: accepts request transactions and classifies them into commands.
// Depends on tws_pkg and tws_in_if.
`timescale 1ns / 1ps
`default_nettype none

module tws_front import tws_pkg::*; (
  tws_in_if.sink   req_i,
  input  logic     full_i,
  output logic     push_o,
  output tws_cmd_t cmd_o
);

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.sda_in = req_i.payload.sda_in;
    unique case (req_i.payload.func)
      FUNC_START: begin
        cmd_o.kind       = CMD_START;
        cmd_o.is_read    = req_i.payload.is_read;
        // Merge the read flag into the address byte
        cmd_o.addr_byte  = ADDR_BYTE_W'(req_i.payload.reg_addr)
                         | (req_i.payload.is_read ? READ_FLAG : '0);
        // Write data only matters for a write
        cmd_o.write_data = req_i.payload.is_read ? '0 : req_i.payload.write_data;
      end
      FUNC_TICK: begin
        cmd_o.kind = CMD_TICK;
      end
      default: begin
        cmd_o.kind = CMD_TICK;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/tws_cmd_queue.sv */
// Short command queue between front and back.
// Depends on tws_pkg for the command struct and depth.
`timescale 1ns / 1ps
`default_nettype none

module tws_cmd_queue import tws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tws_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tws_cmd_t cmd_o
);

  tws_cmd_t                   entry_q [CMD_QUEUE_DEPTH];
  logic [CMD_QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CMD_QUEUE_CNT_W'(CMD_QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  function automatic logic [CMD_QUEUE_PTR_W-1:0] ptr_next(
    input logic [CMD_QUEUE_PTR_W-1:0] ptr
  );
    logic [CMD_QUEUE_PTR_W-1:0] nxt;
    if (ptr == CMD_QUEUE_PTR_W'(CMD_QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tws_back.sv */
// Back end: runs the serial sequencer on queued commands and registers
// one response per command. Depends on tws_pkg and tws_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tws_back import tws_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  tws_cmd_t  cmd_i,
  output logic      pop_o,
  tws_out_if.source rsp_o
);

  localparam int unsigned TotalBits = ADDR_BITS + DATA_BITS;
  localparam int unsigned PhaseW    = $clog2(2 * TotalBits + 3);

  localparam logic [PhaseW-1:0] AddrEnd = PhaseW'(2 * ADDR_BITS);
  localparam logic [PhaseW-1:0] DataEnd = PhaseW'(2 * TotalBits);
  localparam logic [PhaseW-1:0] HoldT   = PhaseW'(2 * TotalBits + 1);

  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [TotalBits-1:0] shift_q, shift_d;
  logic [DATA_BITS-1:0] capture_q, capture_d;
  logic                 read_mode_q, read_mode_d;
  logic                 active_q, active_d;
  logic                 sel_n_q, sel_n_d;
  logic                 sck_q, sck_d;
  logic                 dout_q, dout_d;
  logic                 drive_q, drive_d;

  logic                 out_valid_q, out_valid_d;
  tws_out_t             out_q, out_d;

  logic [PhaseW-1:0]    tick_t;
  logic                 done;
  logic [WORD_W-1:0]    rdata;

  // Take the next command whenever the response register is free or drains
  assign pop_o = !empty_i && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  assign tick_t = phase_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    capture_d   = capture_q;
    read_mode_d = read_mode_q;
    active_d    = active_q;
    sel_n_d     = sel_n_q;
    sck_d       = sck_q;
    dout_d      = dout_q;
    drive_d     = drive_q;
    done        = 1'b0;
    rdata       = '0;

    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_START: begin
          if (!active_q) begin
            read_mode_d = cmd_i.is_read;
            shift_d     = {ADDR_BITS'(cmd_i.addr_byte), DATA_BITS'(cmd_i.write_data)};
            capture_d   = '0;
            phase_d     = '0;
            active_d    = 1'b1;
            sel_n_d     = 1'b0;
            sck_d       = 1'b0;
            dout_d      = 1'b0;
            drive_d     = 1'b1;
          end
        end
        CMD_TICK: begin
          if (active_q) begin
            phase_d = tick_t;
            if ((tick_t <= AddrEnd) || (!read_mode_q && (tick_t <= DataEnd))) begin
              // Odd half: present the bit and raise SCK; even half: drop SCK
              if (tick_t[0]) begin
                drive_d = 1'b1;
                dout_d  = shift_q[TotalBits-1];
                sck_d   = 1'b1;
                shift_d = {shift_q[TotalBits-2:0], 1'b0};
              end else begin
                sck_d = 1'b0;
              end
            end else if (tick_t <= DataEnd) begin
              // Read bit: release the pin, sample as SCK is raised
              drive_d = 1'b0;
              dout_d  = 1'b0;
              if (tick_t[0]) begin
                sck_d = 1'b0;
              end else begin
                sck_d     = 1'b1;
                capture_d = {capture_q[DATA_BITS-2:0], cmd_i.sda_in};
              end
            end else if (tick_t == HoldT) begin
              // Hold half period, pins unchanged
            end else begin
              done     = 1'b1;
              rdata    = read_mode_q ? WORD_W'(capture_q) : '0;
              active_d = 1'b0;
              phase_d  = '0;
              sel_n_d  = 1'b1;
              sck_d    = 1'b0;
              dout_d   = 1'b0;
              drive_d  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d        = 1'b1;
      out_d.select_n     = sel_n_d;
      out_d.serial_clock = sck_d;
      out_d.data_out     = dout_d;
      out_d.data_drive   = drive_d;
      out_d.busy_res     = active_d;
      out_d.done_res     = done;
      out_d.read_data    = rdata;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      shift_q     <= '0;
      capture_q   <= '0;
      read_mode_q <= 1'b0;
      active_q    <= 1'b0;
      sel_n_q     <= 1'b1;
      sck_q       <= 1'b0;
      dout_q      <= 1'b0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      capture_q   <= capture_d;
      read_mode_q <= read_mode_d;
      active_q    <= active_d;
      sel_n_q     <= sel_n_d;
      sck_q       <= sck_d;
      dout_q      <= dout_d;
      drive_q     <= drive_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/three_wire_spi_register_master.sv */
// Top level of the three-wire SPI register master.
// Depends on tws_pkg, tws_if, tws_front, tws_cmd_queue and tws_back.
//
// Usage:
//   req_i carries request transactions: func 0 starts a register read or
//   write (ignored while busy), func 1 advances the serial frame by one half
//   bit period. Every request yields exactly one response transaction on
//   rsp_o with the pin levels after that request (select_n, serial_clock,
//   data_out, data_drive), busy, done and, on the done of a read, the word.
//   A frame is a start, then 2*(ADDR_BITS+DATA_BITS)+2 ticks: address bits,
//   data bits, one hold tick, and a tick that deselects and reports done.
// Throughput: one request per clock cycle sustained while rsp_o is ready; the
//   sequencer in the back end advances once per command that it takes.
// Path: a taken request is first written into the command queue; the back end
//   then pops it and loads the response register when that register is free or
//   drains.
// Stall: when rsp_o is stalled the response register holds, the two-entry
//   command queue absorbs up to two more requests, then req_i.ready drops.
// Reset: asynchronous, active low; the queue empties, the response register
//   goes invalid and the pins return to idle (deselected, SCK low, released).
`timescale 1ns / 1ps
`default_nettype none

module three_wire_spi_register_master import tws_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tws_in_if.sink    req_i,
  tws_out_if.source rsp_o
);

  // Front to queue
  logic     push;
  logic     full;
  tws_cmd_t cmd_in;

  // Queue to back
  logic     pop;
  logic     empty;
  tws_cmd_t cmd_out;

  // Classify requests; hold off while the queue is full
  tws_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // Decouple request acceptance from response backpressure
  tws_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  // Run the frame sequencer and register each response
  tws_back #(
    .DATA_BITS (DATA_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire
